/* rtl/core/dsg_pkg.sv */
// Shared types, constants and helpers for the DWT subband geometry block.
package dsg_pkg;

	localparam int unsigned COORD_BITS_DEF = 32;
	localparam int unsigned LEVEL_BITS     = 4;
	localparam int unsigned MAX_LEVELS     = 8;
	localparam int unsigned NL_RESET       = 5;

	typedef logic [LEVEL_BITS-1:0] level_t;

	typedef enum logic [1:0] {
		KIND_LL = 2'd0,
		KIND_HL = 2'd1,
		KIND_LH = 2'd2,
		KIND_HH = 2'd3
	} band_kind_t;

	// Load commands from the sequencer to the band datapath.
	typedef struct packed {
		logic       load_root;
		logic       load_band;
		logic       advance;
		band_kind_t kind;
		level_t     level;
		level_t     res;
		logic       last;
	} dsg_cmd_t;

	function automatic logic [1:0] band_gain_of(input band_kind_t kind);
		logic [1:0] g;
		unique case (kind)
			KIND_LL: g = 2'd0;
			KIND_HL: g = 2'd1;
			KIND_LH: g = 2'd1;
			KIND_HH: g = 2'd2;
			default: g = 2'd0;
		endcase
		return g;
	endfunction

endpackage

/* rtl/core/dwt_subband_geometry.sv */
// Top level of the DWT subband geometry generator.
// One canvas word (corner and size) yields 1 + 4*L band words, L being the level
// register capped at MAX_LEVELS: the root band, then LL, HL, LH and HH of each level,
// with the final word marked by last_band. Words come from an output register at one
// per cycle while the consumer does not stall, the root band being on show from the
// cycle after the canvas is accepted. The input is stalled from the accepting edge
// until the final band word has been taken, and a new canvas can be accepted from the
// cycle after that. Each level is halved from the LL rectangle of the level above in a
// single parent register, which is why one canvas is worked at a time.
module dwt_subband_geometry import dsg_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] canvas_x0,
	input  logic [COORD_BITS-1:0] canvas_y0,
	input  logic [COORD_BITS-1:0] canvas_width,
	input  logic [COORD_BITS-1:0] canvas_height,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            band_kind,
	output logic [3:0]            band_level,
	output logic [3:0]            resolution_level,
	output logic [1:0]            band_gain,
	output logic [COORD_BITS-1:0] band_x0,
	output logic [COORD_BITS-1:0] band_y0,
	output logic [COORD_BITS-1:0] band_width,
	output logic [COORD_BITS-1:0] band_height,
	output logic [COORD_BITS-1:0] layout_offset_x,
	output logic [COORD_BITS-1:0] layout_offset_y,
	output logic                  last_band
);

	dsg_cmd_t cmd;

	dsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dsg_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk              (clk),
		.cmd              (cmd),
		.canvas_x0        (canvas_x0),
		.canvas_y0        (canvas_y0),
		.canvas_width     (canvas_width),
		.canvas_height    (canvas_height),
		.band_kind        (band_kind),
		.band_level       (band_level),
		.resolution_level (resolution_level),
		.band_gain        (band_gain),
		.band_x0          (band_x0),
		.band_y0          (band_y0),
		.band_width       (band_width),
		.band_height      (band_height),
		.layout_offset_x  (layout_offset_x),
		.layout_offset_y  (layout_offset_y),
		.last_band        (last_band)
	);

endmodule

/* rtl/core/dsg_ctrl.sv */
// Band sequencer: level register, handshakes and per-band load commands.
module dsg_ctrl import dsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  level_t   cfg_wdata,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output dsg_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	localparam level_t MAX_LEVELS_L = LEVEL_BITS'(MAX_LEVELS);
	localparam level_t LEVEL_ONE    = LEVEL_BITS'(1);

	state_t     state_q;
	level_t     num_levels_q;
	level_t     nl_q;
	level_t     level_q;
	band_kind_t step_q;

	level_t     nl_in;
	logic       accept;
	logic       take;
	logic       is_last;
	level_t     next_level;
	band_kind_t next_step;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign take      = (state_q == ST_EMIT) && !out_stall;

	assign nl_in = (num_levels_q > MAX_LEVELS_L) ? MAX_LEVELS_L : num_levels_q;

	// The word on show is the last one once the deepest HH is reached, or the root
	// band alone when no decomposition is asked for.
	assign is_last = (level_q == nl_q) &&
		((level_q == '0) || (step_q == KIND_HH));

	always_comb begin
		if (level_q == '0) begin
			next_level = LEVEL_ONE;
			next_step  = KIND_LL;
		end else if (step_q == KIND_HH) begin
			next_level = level_q + LEVEL_ONE;
			next_step  = KIND_LL;
		end else begin
			next_level = level_q;
			next_step  = band_kind_t'(step_q + 2'd1);
		end
	end

	always_comb begin
		cmd = '0;
		if (accept) begin
			cmd.load_root = 1'b1;
			cmd.kind      = KIND_LL;
			cmd.level     = '0;
			cmd.res       = (nl_in == '0) ? '0 : nl_in + LEVEL_ONE;
			cmd.last      = (nl_in == '0);
		end else begin
			cmd.load_band = take && !is_last;
			cmd.advance   = take && !is_last && (next_step == KIND_HH);
			cmd.kind      = next_step;
			cmd.level     = next_level;
			cmd.res       = ((next_step == KIND_LL) && (next_level == nl_q)) ?
				'0 : nl_q - next_level + LEVEL_ONE;
			cmd.last      = (next_level == nl_q) && (next_step == KIND_HH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			num_levels_q <= LEVEL_BITS'(NL_RESET);
			nl_q         <= '0;
			level_q      <= '0;
			step_q       <= KIND_LL;
		end else begin
			if (cfg_we) begin
				num_levels_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EMIT;
						nl_q    <= nl_in;
						level_q <= '0;
						step_q  <= KIND_LL;
					end
				end
				ST_EMIT: begin
					if (take) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							level_q <= next_level;
							step_q  <= next_step;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/dsg_datapath.sv */
// Parent LL rectangle, child band arithmetic and the output word register.
module dsg_datapath import dsg_pkg::*; #(
	parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  dsg_cmd_t              cmd,
	input  logic [COORD_BITS-1:0] canvas_x0,
	input  logic [COORD_BITS-1:0] canvas_y0,
	input  logic [COORD_BITS-1:0] canvas_width,
	input  logic [COORD_BITS-1:0] canvas_height,
	output logic [1:0]            band_kind,
	output level_t                band_level,
	output level_t                resolution_level,
	output logic [1:0]            band_gain,
	output logic [COORD_BITS-1:0] band_x0,
	output logic [COORD_BITS-1:0] band_y0,
	output logic [COORD_BITS-1:0] band_width,
	output logic [COORD_BITS-1:0] band_height,
	output logic [COORD_BITS-1:0] layout_offset_x,
	output logic [COORD_BITS-1:0] layout_offset_y,
	output logic                  last_band
);

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned EW = COORD_BITS + 1;

	logic [CW-1:0] px0_q, py0_q, pw_q, ph_q;

	logic          hx, hy;
	logic [EW-1:0] sum_x, sum_y, sum_llw, sum_llh, sum_hw, sum_hh;
	logic [CW-1:0] llx, lly, llw, llh, hix, hiy, hw, hh;
	logic [CW-1:0] nx, ny, nw, nh, nox, noy;

	assign hx = px0_q[0];
	assign hy = py0_q[0];

	// Sums are one bit wider so that an odd value at the top of the range cannot wrap.
	assign sum_x   = {1'b0, px0_q} + EW'(1);
	assign sum_y   = {1'b0, py0_q} + EW'(1);
	assign sum_llw = {1'b0, pw_q} + EW'(!hx);
	assign sum_llh = {1'b0, ph_q} + EW'(!hy);
	assign sum_hw  = {1'b0, pw_q} + EW'(hx);
	assign sum_hh  = {1'b0, ph_q} + EW'(hy);

	assign llx = sum_x[CW:1];
	assign lly = sum_y[CW:1];
	assign llw = sum_llw[CW:1];
	assign llh = sum_llh[CW:1];
	assign hw  = sum_hw[CW:1];
	assign hh  = sum_hh[CW:1];
	assign hix = {1'b0, px0_q[CW-1:1]};
	assign hiy = {1'b0, py0_q[CW-1:1]};

	always_comb begin
		case (cmd.kind)
			KIND_LL: begin
				nx = llx; ny = lly; nw = llw; nh = llh; nox = '0;  noy = '0;
			end
			KIND_HL: begin
				nx = hix; ny = lly; nw = hw;  nh = llh; nox = llw; noy = '0;
			end
			KIND_LH: begin
				nx = llx; ny = hiy; nw = llw; nh = hh;  nox = '0;  noy = llh;
			end
			default: begin
				nx = hix; ny = hiy; nw = hw;  nh = hh;  nox = llw; noy = llh;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_root) begin
			px0_q <= canvas_x0;
			py0_q <= canvas_y0;
			pw_q  <= canvas_width;
			ph_q  <= canvas_height;
		end else if (cmd.advance) begin
			// The HH word goes out from the old parent while its LL becomes the next parent.
			px0_q <= llx;
			py0_q <= lly;
			pw_q  <= llw;
			ph_q  <= llh;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_root || cmd.load_band) begin
			band_kind        <= cmd.kind;
			band_level       <= cmd.level;
			resolution_level <= cmd.res;
			band_gain        <= band_gain_of(cmd.kind);
			last_band        <= cmd.last;
		end
		if (cmd.load_root) begin
			band_x0         <= canvas_x0;
			band_y0         <= canvas_y0;
			band_width      <= canvas_width;
			band_height     <= canvas_height;
			layout_offset_x <= '0;
			layout_offset_y <= '0;
		end else if (cmd.load_band) begin
			band_x0         <= nx;
			band_y0         <= ny;
			band_width      <= nw;
			band_height     <= nh;
			layout_offset_x <= nox;
			layout_offset_y <= noy;
		end
	end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the DWT subband geometry generator.
`timescale 1ns / 1ps

module tb;
	import dsg_pkg::*;

	localparam int CW      = COORD_BITS_DEF;
	localparam int NUM_DIR = 18;
	localparam int NUM_SEG = 12;
	localparam int SEG_LEN = 19;

	typedef struct packed {
		band_kind_t    kind;
		logic [3:0]    lev;
		logic [3:0]    res;
		logic [1:0]    gain;
		logic [CW-1:0] x0;
		logic [CW-1:0] y0;
		logic [CW-1:0] wd;
		logic [CW-1:0] ht;
		logic [CW-1:0] ox;
		logic [CW-1:0] oy;
		logic          last;
	} band_t;

	typedef struct packed {
		logic [3:0]    levels;
		logic [CW-1:0] x0;
		logic [CW-1:0] y0;
		logic [CW-1:0] wd;
		logic [CW-1:0] ht;
		logic          typed;
		band_t         want;
	} canvas_row_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [3:0]    cfg_wdata;
	logic          in_valid;
	logic          in_stall;
	logic [CW-1:0] canvas_x0;
	logic [CW-1:0] canvas_y0;
	logic [CW-1:0] canvas_width;
	logic [CW-1:0] canvas_height;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [1:0]    band_kind;
	logic [3:0]    band_level;
	logic [3:0]    resolution_level;
	logic [1:0]    band_gain;
	logic [CW-1:0] band_x0;
	logic [CW-1:0] band_y0;
	logic [CW-1:0] band_width;
	logic [CW-1:0] band_height;
	logic [CW-1:0] layout_offset_x;
	logic [CW-1:0] layout_offset_y;
	logic          last_band;

	band_t       pending_bands[$];
	logic [3:0]  levels_reg = 4'(NL_RESET);
	logic        use_typed = 1'b0;
	band_t       typed_band = '0;
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	canvas_row_t dir_rows [NUM_DIR];

	dwt_subband_geometry uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.canvas_x0        (canvas_x0),
		.canvas_y0        (canvas_y0),
		.canvas_width     (canvas_width),
		.canvas_height    (canvas_height),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.band_kind        (band_kind),
		.band_level       (band_level),
		.resolution_level (resolution_level),
		.band_gain        (band_gain),
		.band_x0          (band_x0),
		.band_y0          (band_y0),
		.band_width       (band_width),
		.band_height      (band_height),
		.layout_offset_x  (layout_offset_x),
		.layout_offset_y  (layout_offset_y),
		.last_band        (last_band)
	);

	always #5 clk = ~clk;

	task automatic flag_mismatch(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		if (got !== want) begin
			flag_mismatch(what, got, want);
		end
	endtask

	function automatic void push_band(input band_kind_t kind, input logic [3:0] lev,
			input logic [3:0] res, input logic [CW-1:0] x0, input logic [CW-1:0] y0,
			input logic [CW-1:0] wd, input logic [CW-1:0] ht, input logic [CW-1:0] ox,
			input logic [CW-1:0] oy, input logic last);
		band_t b;
		b.kind = kind;
		b.lev  = lev;
		b.res  = res;
		case (kind) inside
			KIND_LL: b.gain = 2'd0;
			KIND_HL, KIND_LH: b.gain = 2'd1;
			default: b.gain = 2'd2;
		endcase
		b.x0   = x0;
		b.y0   = y0;
		b.wd   = wd;
		b.ht   = ht;
		b.ox   = ox;
		b.oy   = oy;
		b.last = last;
		pending_bands.push_back(b);
	endfunction

	// Works out every band of one canvas under the current level setting.
	// The halving is done one bit wider so that an odd corner at the top of the
	// range does not wrap.
	function automatic void expand_canvas(input logic [CW-1:0] cx0, input logic [CW-1:0] cy0,
			input logic [CW-1:0] cw, input logic [CW-1:0] ch);
		logic [CW:0] px, py, pw, ph, llx, lly, llw, llh, hix, hiy, hw, hh;
		logic [3:0]  nl, res;
		logic        hx, hy, deep;
		nl = (levels_reg > MAX_LEVELS) ? 4'(MAX_LEVELS) : levels_reg;
		px = {1'b0, cx0};
		py = {1'b0, cy0};
		pw = {1'b0, cw};
		ph = {1'b0, ch};
		push_band(KIND_LL, 4'd0, (nl != 4'd0) ? nl + 4'd1 : 4'd0, cx0, cy0, cw, ch,
			'0, '0, nl == 4'd0);
		for (int lev = 1; lev <= nl; lev++) begin
			hx   = px[0];
			hy   = py[0];
			res  = 4'(nl - lev + 1);
			deep = (lev == nl);
			llx  = (px + 1) >> 1;
			lly  = (py + 1) >> 1;
			llw  = (pw + 1 - hx) >> 1;
			llh  = (ph + 1 - hy) >> 1;
			hix  = px >> 1;
			hiy  = py >> 1;
			hw   = (pw + hx) >> 1;
			hh   = (ph + hy) >> 1;
			push_band(KIND_LL, 4'(lev), deep ? 4'd0 : res, llx[CW-1:0], lly[CW-1:0],
				llw[CW-1:0], llh[CW-1:0], '0, '0, 1'b0);
			push_band(KIND_HL, 4'(lev), res, hix[CW-1:0], lly[CW-1:0], hw[CW-1:0],
				llh[CW-1:0], llw[CW-1:0], '0, 1'b0);
			push_band(KIND_LH, 4'(lev), res, llx[CW-1:0], hiy[CW-1:0], llw[CW-1:0],
				hh[CW-1:0], '0, llh[CW-1:0], 1'b0);
			push_band(KIND_HH, 4'(lev), res, hix[CW-1:0], hiy[CW-1:0], hw[CW-1:0],
				hh[CW-1:0], llw[CW-1:0], llh[CW-1:0], deep);
			px = llx;
			py = lly;
			pw = llw;
			ph = llh;
		end
	endfunction

	function automatic logic [CW-1:0] random_coord();
		logic [CW-1:0] v;
		case ($urandom_range(0, 3))
			0: v = CW'($urandom_range(0, 15));
			1: v = CW'($urandom);
			2: v = {CW{1'b1}} - CW'($urandom_range(0, 15));
			default: v = CW'($urandom) >> $urandom_range(1, CW - 1);
		endcase
		return v;
	endfunction

	// Band words are checked first; a canvas word taken at the same edge can only
	// yield bands at later edges.
	always @(posedge clk) begin : band_monitor
		band_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_bands.size() == 0) begin
					flag_mismatch("unexpected band word, kind", CW'(band_kind), '0);
				end else begin
					want = pending_bands.pop_front();
					check_field("band_kind", CW'(band_kind), CW'(want.kind));
					check_field("band_level", CW'(band_level), CW'(want.lev));
					check_field("resolution_level", CW'(resolution_level), CW'(want.res));
					check_field("band_gain", CW'(band_gain), CW'(want.gain));
					check_field("band_x0", band_x0, want.x0);
					check_field("band_y0", band_y0, want.y0);
					check_field("band_width", band_width, want.wd);
					check_field("band_height", band_height, want.ht);
					check_field("layout_offset_x", layout_offset_x, want.ox);
					check_field("layout_offset_y", layout_offset_y, want.oy);
					check_field("last_band", CW'(last_band), CW'(want.last));
				end
			end
			if (in_valid && !in_stall) begin
				if (use_typed) begin
					pending_bands.push_back(typed_band);
				end else begin
					expand_canvas(canvas_x0, canvas_y0, canvas_width, canvas_height);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	task automatic send_canvas(input logic [CW-1:0] x0, input logic [CW-1:0] y0,
			input logic [CW-1:0] wd, input logic [CW-1:0] ht, input logic typed,
			input band_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		use_typed     = typed;
		typed_band    = want;
		in_valid      <= 1'b1;
		canvas_x0     <= x0;
		canvas_y0     <= y0;
		canvas_width  <= wd;
		canvas_height <= ht;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		@(negedge clk);
	endtask

	// The level register is only written once every band of the last canvas is in.
	task automatic write_levels(input logic [3:0] v);
		in_valid <= 1'b0;
		while (pending_bands.size() != 0) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
		levels_reg = v;
	endtask

	initial begin
		#5_000_000;
		$display("[dwt_subband_geometry] ERROR");
		$finish;
	end

	initial begin
		logic [3:0] seg_levels [NUM_SEG];
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 4'd0;
		in_valid      = 1'b0;
		canvas_x0     = '0;
		canvas_y0     = '0;
		canvas_width  = '0;
		canvas_height = '0;
		seg_levels    = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd9, 4'd6, 4'd2, 4'd8, 4'd5,
			4'd4, 4'd7};
		// A band is only typed in where the level count is zero: the canvas comes
		// straight back as the root band, marked last.
		dir_rows = '{
			'{4'd5, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
			'{4'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, '0},
			'{4'd5, 32'h1, 32'h1, 32'h1, 32'h1, 1'b0, '0},
			'{4'd5, 32'hfffffffe, 32'hfffffffe, 32'hffffffff, 32'hffffffff, 1'b0, '0},
			'{4'd5, 32'h12345678, 32'h9abcdef1, 32'd1920, 32'd1080, 1'b0, '0},
			'{4'd5, 32'd3, 32'd5, 32'd100, 32'd64, 1'b0, '0},
			'{4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1,
				'{KIND_LL, 4'd0, 4'd0, 2'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
			'{4'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
				'{KIND_LL, 4'd0, 4'd0, 2'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
				32'hffffffff, 32'h0, 32'h0, 1'b1}},
			'{4'd0, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'hc3c3c3c3, 32'h3c3c3c3c, 1'b1,
				'{KIND_LL, 4'd0, 4'd0, 2'd0, 32'ha5a5a5a5, 32'h5a5a5a5a, 32'hc3c3c3c3,
				32'h3c3c3c3c, 32'h0, 32'h0, 1'b1}},
			'{4'd8, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, '0},
			'{4'd8, 32'd7, 32'd9, 32'd4096, 32'd2160, 1'b0, '0},
			'{4'd8, 32'h0, 32'h0, 32'h1, 32'h1, 1'b0, '0},
			'{4'd15, 32'h1, 32'h0, 32'd255, 32'd256, 1'b0, '0},
			'{4'd15, 32'hffffffff, 32'h0, 32'h0, 32'hffffffff, 1'b0, '0},
			'{4'd1, 32'h0, 32'h1, 32'h2, 32'h3, 1'b0, '0},
			'{4'd1, 32'h1, 32'h0, 32'h3, 32'h2, 1'b0, '0},
			'{4'd1, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, '0},
			'{4'd9, 32'h5, 32'h6, 32'h7, 32'h8, 1'b0, '0}
		};
		send_idle_pct  = 9;
		recv_stall_pct = 61;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The first rows run on the level count left by reset.
		for (int i = 0; i < NUM_DIR; i++) begin
			if (dir_rows[i].levels != levels_reg) begin
				write_levels(dir_rows[i].levels);
			end
			send_canvas(dir_rows[i].x0, dir_rows[i].y0, dir_rows[i].wd, dir_rows[i].ht,
				dir_rows[i].typed, dir_rows[i].want);
		end

		for (int seg = 0; seg < NUM_SEG; seg++) begin
			if (seg == NUM_SEG / 3) begin
				send_idle_pct  = 61;
				recv_stall_pct = 9;
			end else if (seg == 2 * NUM_SEG / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			write_levels(seg_levels[seg]);
			for (int i = 0; i < SEG_LEN; i++) begin
				send_canvas(random_coord(), random_coord(), random_coord(), random_coord(),
					1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (pending_bands.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0) begin
			$display("[dwt_subband_geometry] OK");
		end else begin
			$display("[dwt_subband_geometry] ERROR");
		end
		$finish;
	end

endmodule

/* dwt_subband_geometry.f */
rtl/core/dsg_pkg.sv
rtl/core/dsg_ctrl.sv
rtl/core/dsg_datapath.sv
rtl/core/dwt_subband_geometry.sv
tb/sv/tb.sv
